/* rtl/core/lhp_pkg.sv */
// Shared types and constants for the latency histogram percentile unit.
package lhp_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int OPC_W       = 2;
    localparam int LIMIT_W     = 32;
    localparam int PCT_W       = 7;
    localparam int COUNT_W     = 32;
    localparam int SUM_W       = 64;
    localparam int HIT_W       = 4;
    localparam int CFG_IDX_W   = 4;
    localparam int LIMIT_REGS  = 8;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 200;

    // Product of a 32-bit count and a 7-bit percent.
    localparam int PROD_W        = COUNT_W + PCT_W;
    localparam int PERCENT_SCALE = 100;

    typedef logic [LIMIT_W-1:0] limit_t;

    // Reset values of the bucket upper limits.
    localparam limit_t LIMIT_RESET [LIMIT_REGS] = '{
        32'd1000, 32'd5000, 32'd10000, 32'd50000,
        32'd100000, 32'd500000, 32'd1000000, 32'd5000000
    };

    // Input opcodes.
    localparam logic [OPC_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OPC_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd2;

    // Decoded item kind handed from the front end to the back end.
    typedef enum logic [1:0] {
        KIND_RECORD,
        KIND_QUERY,
        KIND_CLEAR,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [LIMIT_W-1:0] sample;
        logic [PCT_W-1:0]   pct;
    } cmd_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REC_FIND,
        ST_REC_UPDATE,
        ST_APPLY,
        ST_QRY_MUL,
        ST_QRY_SCALE,
        ST_QRY_ACCUM
    } state_t;

    // One result item.
    typedef struct packed {
        logic [LIMIT_W-1:0] largest;
        logic [LIMIT_W-1:0] smallest;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic [HIT_W-1:0]   hit;
        logic [LIMIT_W-1:0] answer;
    } result_t;

endpackage

/* rtl/core/lhp_front.sv */
// Front end: accepts input transactions, decodes them and queues commands.
module lhp_front #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lhp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            cmd_valid,
    input  logic                            cmd_ready,
    output lhp_pkg::cmd_t                   cmd
);

    localparam int SW      = (SAMPLE_BITS < lhp_pkg::LIMIT_W) ? SAMPLE_BITS : lhp_pkg::LIMIT_W;
    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);

    logic [lhp_pkg::OPC_W-1:0]   in_opcode;
    logic [lhp_pkg::LIMIT_W-1:0] in_sample;
    logic [lhp_pkg::PCT_W-1:0]   in_pct;
    lhp_pkg::cmd_t               decoded;

    lhp_pkg::cmd_t    entries_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   fill_reg;
    logic [PTR_W:0]   fill_next;
    logic             push;
    logic             pop;

    // Unpack the input fields.
    assign in_opcode = s_axis_tdata[1:0];
    assign in_sample = s_axis_tdata[33:2];
    assign in_pct    = s_axis_tdata[40:34];

    // Classify the opcode and trim the sample to the configured width.
    always_comb
    begin
        case (in_opcode)
            lhp_pkg::OP_RECORD: decoded.kind = lhp_pkg::KIND_RECORD;
            lhp_pkg::OP_QUERY:  decoded.kind = lhp_pkg::KIND_QUERY;
            lhp_pkg::OP_CLEAR:  decoded.kind = lhp_pkg::KIND_CLEAR;
            default:            decoded.kind = lhp_pkg::KIND_NOP;
        endcase
        decoded.sample = lhp_pkg::LIMIT_W'(in_sample[SW-1:0]);
        decoded.pct    = in_pct;
    end

    // Queue handshakes.
    assign s_axis_tready = (fill_reg != (PTR_W+1)'(Q_DEPTH));
    assign cmd_valid     = (fill_reg != '0);
    assign cmd           = entries_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = cmd_valid && cmd_ready;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

/* rtl/core/lhp_back.sv */
// Back end: executes record, query and clear commands on the histogram state.
module lhp_back #(
    parameter int BUCKETS     = 8,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  lhp_pkg::cmd_t        cmd,
    input  lhp_pkg::limit_t      limits [BUCKETS],
    output logic                 res_valid,
    input  logic                 res_ready,
    output lhp_pkg::result_t     res
);

    localparam int SW     = (SAMPLE_BITS < lhp_pkg::LIMIT_W) ? SAMPLE_BITS : lhp_pkg::LIMIT_W;
    localparam int IDX_W  = $clog2(BUCKETS);
    localparam int HIT_IW = $clog2(BUCKETS + 1);
    localparam int ACC_W  = lhp_pkg::PROD_W + $clog2(BUCKETS) + 1;
    localparam int CW     = lhp_pkg::COUNT_W;

    lhp_pkg::state_t state_reg;
    lhp_pkg::state_t state_next;
    lhp_pkg::cmd_t   cmd_reg;
    lhp_pkg::cmd_t   cmd_next;

    logic [HIT_IW-1:0]         hit_reg;
    logic [HIT_IW-1:0]         hit_next;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          idx_next;
    logic [lhp_pkg::PROD_W-1:0] prod_reg;
    logic [lhp_pkg::PROD_W-1:0] prod_next;
    logic [lhp_pkg::PROD_W-1:0] scaled_reg;
    logic [lhp_pkg::PROD_W-1:0] scaled_next;
    logic [ACC_W-1:0]          acc_reg;
    logic [ACC_W-1:0]          acc_next;
    logic [ACC_W-1:0]          acc_sum;

    logic [CW-1:0]               counts_reg [BUCKETS];
    logic [CW-1:0]               counts_next [BUCKETS];
    logic [CW-1:0]               total_reg;
    logic [CW-1:0]               total_next;
    logic [lhp_pkg::SUM_W-1:0]   sum_reg;
    logic [lhp_pkg::SUM_W-1:0]   sum_next;
    logic [SW-1:0]               least_reg;
    logic [SW-1:0]               least_next;
    logic [SW-1:0]               greatest_reg;
    logic [SW-1:0]               greatest_next;

    logic                        res_valid_reg;
    logic                        res_valid_next;
    lhp_pkg::result_t            res_reg;
    lhp_pkg::result_t            res_next;

    logic                        slot_free;
    logic                        finish;
    logic [lhp_pkg::LIMIT_W-1:0] answer_val;
    logic [lhp_pkg::HIT_W-1:0]   hit_val;
    logic [SW-1:0]               sample_w;

    assign slot_free = !res_valid_reg || res_ready;
    assign sample_w  = cmd_reg.sample[SW-1:0];
    assign acc_sum   = acc_reg + ACC_W'(scaled_reg);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Sequencer: next state, datapath updates and result capture.
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        hit_next      = hit_reg;
        idx_next      = idx_reg;
        prod_next     = prod_reg;
        scaled_next   = scaled_reg;
        acc_next      = acc_reg;
        counts_next   = counts_reg;
        total_next    = total_reg;
        sum_next      = sum_reg;
        least_next    = least_reg;
        greatest_next = greatest_reg;
        cmd_ready     = 1'b0;
        finish        = 1'b0;
        answer_val    = '0;
        hit_val       = lhp_pkg::HIT_W'(BUCKETS);

        case (state_reg)
            lhp_pkg::ST_IDLE:
            begin
                // Take a command only when the result register will be free.
                cmd_ready = slot_free;
                if (cmd_valid && slot_free)
                begin
                    cmd_next = cmd;
                    case (cmd.kind)
                        lhp_pkg::KIND_RECORD: state_next = lhp_pkg::ST_REC_FIND;
                        lhp_pkg::KIND_QUERY:  state_next = lhp_pkg::ST_QRY_MUL;
                        default:              state_next = lhp_pkg::ST_APPLY;
                    endcase
                end
            end

            lhp_pkg::ST_REC_FIND:
            begin
                // First bucket whose limit covers the sample; lowest index wins.
                hit_next = HIT_IW'(BUCKETS);
                for (int j = BUCKETS - 1; j >= 0; j--)
                begin
                    if (lhp_pkg::LIMIT_W'(sample_w) <= limits[j])
                    begin
                        hit_next = HIT_IW'(j);
                    end
                end
                state_next = lhp_pkg::ST_REC_UPDATE;
            end

            lhp_pkg::ST_REC_UPDATE:
            begin
                for (int j = 0; j < BUCKETS; j++)
                begin
                    if (hit_reg == HIT_IW'(j))
                    begin
                        counts_next[j] = counts_reg[j] + 1'b1;
                    end
                end
                total_next = total_reg + 1'b1;
                sum_next   = sum_reg + lhp_pkg::SUM_W'(sample_w);
                if (sample_w < least_reg)
                begin
                    least_next = sample_w;
                end
                if (sample_w > greatest_reg)
                begin
                    greatest_next = sample_w;
                end
                hit_val    = lhp_pkg::HIT_W'(hit_reg);
                finish     = 1'b1;
                state_next = lhp_pkg::ST_IDLE;
            end

            lhp_pkg::ST_APPLY:
            begin
                // Clear empties the statistics; an unused opcode reports them.
                if (cmd_reg.kind == lhp_pkg::KIND_CLEAR)
                begin
                    for (int j = 0; j < BUCKETS; j++)
                    begin
                        counts_next[j] = '0;
                    end
                    total_next    = '0;
                    sum_next      = '0;
                    least_next    = '1;
                    greatest_next = '0;
                end
                finish     = 1'b1;
                state_next = lhp_pkg::ST_IDLE;
            end

            lhp_pkg::ST_QRY_MUL:
            begin
                // The target test acc >= count*pct/100 becomes 100*acc + 99 >= count*pct.
                if (total_reg == '0)
                begin
                    finish     = 1'b1;
                    state_next = lhp_pkg::ST_IDLE;
                end
                else
                begin
                    prod_next  = lhp_pkg::PROD_W'(total_reg) * lhp_pkg::PROD_W'(cmd_reg.pct);
                    acc_next   = ACC_W'(lhp_pkg::PERCENT_SCALE - 1);
                    idx_next   = '0;
                    state_next = lhp_pkg::ST_QRY_SCALE;
                end
            end

            lhp_pkg::ST_QRY_SCALE:
            begin
                scaled_next = lhp_pkg::PROD_W'(counts_reg[idx_reg])
                              * lhp_pkg::PROD_W'(lhp_pkg::PERCENT_SCALE);
                state_next  = lhp_pkg::ST_QRY_ACCUM;
            end

            lhp_pkg::ST_QRY_ACCUM:
            begin
                acc_next = acc_sum;
                if (acc_sum >= ACC_W'(prod_reg))
                begin
                    answer_val = limits[idx_reg];
                    finish     = 1'b1;
                    state_next = lhp_pkg::ST_IDLE;
                end
                else if (idx_reg == IDX_W'(BUCKETS - 1))
                begin
                    // No bucket reached the target: report the maximum.
                    answer_val = lhp_pkg::LIMIT_W'(greatest_reg);
                    finish     = 1'b1;
                    state_next = lhp_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = lhp_pkg::ST_QRY_SCALE;
                end
            end

            default:
            begin
                state_next = lhp_pkg::ST_IDLE;
            end
        endcase

        // Result register: loaded on completion, emptied when taken.
        res_next.answer   = answer_val;
        res_next.hit      = hit_val;
        res_next.count    = total_next;
        res_next.sum      = sum_next;
        res_next.smallest = lhp_pkg::LIMIT_W'(least_next);
        res_next.largest  = lhp_pkg::LIMIT_W'(greatest_next);
        if (finish)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Control and histogram state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lhp_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
            for (int j = 0; j < BUCKETS; j++)
            begin
                counts_reg[j] <= '0;
            end
            total_reg     <= '0;
            sum_reg       <= '0;
            least_reg     <= '1;
            greatest_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            counts_reg    <= counts_next;
            total_reg     <= total_next;
            sum_reg       <= sum_next;
            least_reg     <= least_next;
            greatest_reg  <= greatest_next;
        end
    end

    // Working registers of the current command.
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        hit_reg    <= hit_next;
        idx_reg    <= idx_next;
        prod_reg   <= prod_next;
        scaled_reg <= scaled_next;
        acc_reg    <= acc_next;
        if (finish)
        begin
            res_reg <= res_next;
        end
    end

endmodule

/* rtl/core/latency_histogram_percentile_unit.sv */
// Top level of the latency histogram percentile unit.
// Records latency samples into up to eight buckets bounded by programmable upper limits,
// keeps count, wrapping sum, minimum and maximum, and answers percentile queries with
// the limit of the first bucket whose cumulative count reaches count*percent/100
// (the maximum if none does, zero when empty). Items enter a two-entry command queue
// and are executed one at a time by a sequencer; one result transaction leaves per item.
// Execution steps: clear and unused opcodes complete in the apply state, a record does
// a limit compare, then an update, and a query multiplies count by percent, then scans
// at most BUCKETS buckets, scaling one bucket count by 100 and accumulating it per
// bucket. Limit writes on the cfg channel are always ready and take effect on the
// next cycle.
module latency_histogram_percentile_unit #(
    parameter int BUCKETS     = 8,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_axis_tdata: opcode[1:0], sample_value[33:2], percent_rank[40:34], zero fill.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [lhp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // m_axis_tdata: answer[31:0], bucket_hit[35:32], sample_count[67:36],
    // sample_sum[131:68], smallest[163:132], largest[195:164], zero fill.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [lhp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lhp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lhp_pkg::LIMIT_W-1:0]       cfg_data
);

    lhp_pkg::limit_t  limits_reg [BUCKETS];
    lhp_pkg::cmd_t    cmd;
    logic             cmd_valid;
    logic             cmd_ready;
    lhp_pkg::result_t res;

    // Bucket limit registers; writes beyond the used buckets are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < BUCKETS; j++)
            begin
                limits_reg[j] <= lhp_pkg::LIMIT_RESET[j];
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int j = 0; j < BUCKETS; j++)
            begin
                if (cfg_index == lhp_pkg::CFG_IDX_W'(j))
                begin
                    limits_reg[j] <= cfg_data;
                end
            end
        end
    end

    lhp_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    lhp_back #(
        .BUCKETS     (BUCKETS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .limits    (limits_reg),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {4'b0000, res.largest, res.smallest, res.sum,
                           res.count, res.hit, res.answer};

endmodule

/* rtl/core/lhp_checker.sv */
// Port-level assertions for the latency histogram percentile unit, with its bind.
module lhp_checker #(
    parameter int BUCKETS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [lhp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The bucket index never exceeds the no-bucket code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[35:32] <= 4'(BUCKETS))
        else $error("bucket_hit out of range");

    // A result with a bucket hit, which only a record gives, carries a zero answer.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[35:32] != 4'(BUCKETS)) |-> m_axis_tdata[31:0] == 32'd0)
        else $error("record result with nonzero answer");

    // With samples present, the minimum does not exceed the maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[67:36] != 32'd0)
            |-> m_axis_tdata[163:132] <= m_axis_tdata[195:164])
        else $error("smallest above largest");

endmodule

bind latency_histogram_percentile_unit lhp_checker #(
    .BUCKETS (BUCKETS)
) u_lhp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/tb_latency_histogram_percentile_unit.sv */
// Self-checking testbench for the latency histogram percentile unit.
module tb_latency_histogram_percentile_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int BUCKETS        = 8;
    localparam int RESULT_W       = $bits(lhp_pkg::result_t);
    // Tail waited at the end, sized for a full query scan plus output staging.
    localparam int LATENCY_TAIL   = 2 * (2 + 2 * BUCKETS);
    localparam int HOLD_CYCLES    = 80;
    // Quiet cycles allowed: the long receiver hold plus a worst-case query and generous
    // random gaps on both sides, taken several times over.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIRECTED_COUNT = 25;
    localparam int PHASE_COUNT    = 7;
    localparam int PRESSURE_PHASE = 4;

    // Opcode the block must treat as a no-op.
    localparam logic [lhp_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [lhp_pkg::CFG_IDX_W-1:0] REG_LIMIT_0   = 4'd0;
    localparam logic [lhp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED  = 4'd15;

    typedef enum int {PACE_FREE, PACE_SRC, PACE_SNK, PACE_BOTH} pace_t;
    typedef enum int {LIM_RESET, LIM_ONES, LIM_ZEROS, LIM_TIGHT, LIM_SHUFFLED, LIM_WIDE}
        limit_plan_t;

    typedef struct packed {
        logic [lhp_pkg::OPC_W-1:0]   op;
        logic [lhp_pkg::LIMIT_W-1:0] sample;
        logic [lhp_pkg::PCT_W-1:0]   pct;
    } hist_item_t;

    typedef struct packed {
        logic [lhp_pkg::OPC_W-1:0]   op;
        logic [lhp_pkg::LIMIT_W-1:0] sample;
        logic [lhp_pkg::PCT_W-1:0]   pct;
        logic                        typed;
        lhp_pkg::result_t            want;
    } probe_row_t;

    // Fields: largest, smallest, sum, count, hit, answer.
    localparam lhp_pkg::result_t EMPTY_STATS =
        '{32'h0, 32'hFFFF_FFFF, 64'h0, 32'd0, 4'd8, 32'h0};
    localparam lhp_pkg::result_t FIRST_ZERO  = '{32'h0, 32'h0, 64'h0, 32'd1, 4'd0, 32'h0};
    localparam lhp_pkg::result_t THEN_MAX    =
        '{32'hFFFF_FFFF, 32'h0, 64'hFFFF_FFFF, 32'd2, 4'd8, 32'h0};
    localparam lhp_pkg::result_t UNTYPED     = '0;

    // Directed probes; rows without a typed result are checked against the predictor.
    localparam probe_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{lhp_pkg::OP_QUERY,  32'd0,          7'd50,  1'b1, EMPTY_STATS},
        '{OP_UNUSED,          32'd0,          7'd0,   1'b1, EMPTY_STATS},
        '{lhp_pkg::OP_CLEAR,  32'd0,          7'd0,   1'b1, EMPTY_STATS},
        '{lhp_pkg::OP_RECORD, 32'd0,          7'd0,   1'b1, FIRST_ZERO},
        '{lhp_pkg::OP_RECORD, 32'hFFFF_FFFF,  7'd0,   1'b1, THEN_MAX},
        '{lhp_pkg::OP_RECORD, 32'd1000,       7'd0,   1'b0, UNTYPED},
        '{lhp_pkg::OP_RECORD, 32'd1001,       7'd0,   1'b0, UNTYPED},
        '{lhp_pkg::OP_RECORD, 32'd5000000,    7'd0,   1'b0, UNTYPED},
        '{lhp_pkg::OP_RECORD, 32'd5000001,    7'd0,   1'b0, UNTYPED},
        '{lhp_pkg::OP_RECORD, 32'h5555_5555,  7'd0,   1'b0, UNTYPED},
        '{lhp_pkg::OP_RECORD, 32'hAAAA_AAAA,  7'd0,   1'b0, UNTYPED},
        '{lhp_pkg::OP_QUERY,  32'd0,          7'd0,   1'b0, UNTYPED},
        '{lhp_pkg::OP_QUERY,  32'd0,          7'd1,   1'b0, UNTYPED},
        '{lhp_pkg::OP_QUERY,  32'd0,          7'd50,  1'b0, UNTYPED},
        '{lhp_pkg::OP_QUERY,  32'd0,          7'd100, 1'b0, UNTYPED},
        '{lhp_pkg::OP_QUERY,  32'd0,          7'd127, 1'b0, UNTYPED},
        '{OP_UNUSED,          32'hAAAA_AAAA,  7'd127, 1'b0, UNTYPED},
        '{lhp_pkg::OP_RECORD, 32'd5000,       7'd127, 1'b0, UNTYPED},
        '{lhp_pkg::OP_QUERY,  32'h5555_5555,  7'd99,  1'b0, UNTYPED},
        '{lhp_pkg::OP_CLEAR,  32'hFFFF_FFFF,  7'd127, 1'b0, UNTYPED},
        '{lhp_pkg::OP_QUERY,  32'd0,          7'd100, 1'b1, EMPTY_STATS},
        '{lhp_pkg::OP_RECORD, 32'd42,         7'd0,   1'b0, UNTYPED},
        '{lhp_pkg::OP_QUERY,  32'd0,          7'd100, 1'b0, UNTYPED},
        '{lhp_pkg::OP_RECORD, 32'hFFFF_FFFF,  7'd0,   1'b0, UNTYPED},
        '{lhp_pkg::OP_QUERY,  32'd0,          7'd100, 1'b0, UNTYPED}
    };

    // Random phases: limit setting, pacing and number of items.
    localparam limit_plan_t PHASE_LIMITS [PHASE_COUNT] =
        '{LIM_RESET, LIM_ONES, LIM_ZEROS, LIM_TIGHT, LIM_SHUFFLED, LIM_WIDE, LIM_RESET};
    localparam pace_t PHASE_PACE [PHASE_COUNT] =
        '{PACE_FREE, PACE_SRC, PACE_SNK, PACE_BOTH, PACE_FREE, PACE_SRC, PACE_SNK};
    localparam int PHASE_ITEMS [PHASE_COUNT] = '{100, 80, 80, 120, 120, 120, 120};

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lhp_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lhp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [lhp_pkg::CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [lhp_pkg::LIMIT_W-1:0]     cfg_data      = '0;

    // Predictor state: limits and histogram contents as the block should hold them.
    logic [lhp_pkg::LIMIT_W-1:0] bin_limit [lhp_pkg::LIMIT_REGS];
    logic [lhp_pkg::COUNT_W-1:0] hist_bins [lhp_pkg::LIMIT_REGS];
    logic [lhp_pkg::COUNT_W-1:0] hist_count;
    logic [lhp_pkg::SUM_W-1:0]   hist_sum;
    logic [lhp_pkg::LIMIT_W-1:0] hist_min;
    logic [lhp_pkg::LIMIT_W-1:0] hist_max;

    lhp_pkg::result_t pending_results [$];
    int               mismatch_count = 0;
    int               src_idle_pct   = 0;
    int               snk_stall_pct  = 0;
    int               hold_token     = 0;

    latency_histogram_percentile_unit #(
        .BUCKETS     (BUCKETS),
        .SAMPLE_BITS (32)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Empty the histogram; the limits stay as they are.
    function automatic void clear_histogram();
        int i;
        for (i = 0; i < lhp_pkg::LIMIT_REGS; i++)
        begin
            hist_bins[i] = '0;
        end
        hist_count = '0;
        hist_sum   = '0;
        hist_min   = '1;
        hist_max   = '0;
    endfunction

    // Apply one item to the predicted histogram and return the result it should produce.
    function automatic lhp_pkg::result_t histogram_outcome(
        input logic [lhp_pkg::OPC_W-1:0]   op,
        input logic [lhp_pkg::LIMIT_W-1:0] sample,
        input logic [lhp_pkg::PCT_W-1:0]   pct);
        lhp_pkg::result_t r;
        logic [63:0]      target;
        logic [63:0]      running;
        bit               found;
        int               i;
        r       = '0;
        r.hit   = lhp_pkg::HIT_W'(BUCKETS);
        found   = 1'b0;
        running = '0;
        case (op)
            lhp_pkg::OP_RECORD:
            begin
                // First bucket whose limit covers the sample wins.
                for (i = 0; i < BUCKETS; i++)
                begin
                    if (!found && sample <= bin_limit[i])
                    begin
                        hist_bins[i] = hist_bins[i] + 1'b1;
                        r.hit        = lhp_pkg::HIT_W'(i);
                        found        = 1'b1;
                    end
                end
                hist_count = hist_count + 1'b1;
                hist_sum   = hist_sum + lhp_pkg::SUM_W'(sample);
                if (sample < hist_min)
                    hist_min = sample;
                if (sample > hist_max)
                    hist_max = sample;
            end
            lhp_pkg::OP_QUERY:
            begin
                if (hist_count != 0)
                begin
                    target   = (64'(hist_count) * 64'(pct)) / 64'(lhp_pkg::PERCENT_SCALE);
                    r.answer = hist_max;
                    for (i = 0; i < BUCKETS; i++)
                    begin
                        if (!found)
                        begin
                            running = running + 64'(hist_bins[i]);
                            if (running >= target)
                            begin
                                r.answer = bin_limit[i];
                                found    = 1'b1;
                            end
                        end
                    end
                end
            end
            lhp_pkg::OP_CLEAR:
                clear_histogram();
            default:
                ;
        endcase
        r.count    = hist_count;
        r.sum      = hist_sum;
        r.smallest = hist_min;
        r.largest  = hist_max;
        return r;
    endfunction

    // Random item, weighted toward records and queries, with samples often near bucket limits.
    function automatic hist_item_t random_item();
        hist_item_t  it;
        logic [31:0] lim;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 62)
            it.op = lhp_pkg::OP_RECORD;
        else if (pick < 88)
            it.op = lhp_pkg::OP_QUERY;
        else if (pick < 94)
            it.op = lhp_pkg::OP_CLEAR;
        else
            it.op = OP_UNUSED;
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                lim       = bin_limit[$urandom_range(BUCKETS - 1)];
                it.sample = lim + 32'($urandom_range(2)) - 32'd1;
            end
            4, 5:
                it.sample = $urandom();
            6, 7:
                it.sample = $urandom_range(0, bin_limit[BUCKETS - 1]);
            8:
                it.sample = '0;
            default:
                it.sample = '1;
        endcase
        if ($urandom_range(99) < 85)
            it.pct = lhp_pkg::PCT_W'($urandom_range(0, 100));
        else
            it.pct = lhp_pkg::PCT_W'($urandom_range(101, 127));
        return it;
    endfunction

    // Offer one item, wait for its transaction, then record the expected result.
    task automatic send_item(input logic [lhp_pkg::OPC_W-1:0] op,
                             input logic [lhp_pkg::LIMIT_W-1:0] sample,
                             input logic [lhp_pkg::PCT_W-1:0] pct, input logic typed,
                             input lhp_pkg::result_t want);
        lhp_pkg::result_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, pct, sample, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = histogram_outcome(op, sample, pct);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Stop offering items and wait until every expected result has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // One register write on the configuration channel; the caller releases valid.
    task automatic write_reg(input logic [lhp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lhp_pkg::LIMIT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < lhp_pkg::LIMIT_REGS)
            bin_limit[idx] = val;
    endtask

    // Program all eight limits according to a plan.
    task automatic program_limits(input limit_plan_t plan);
        logic [lhp_pkg::LIMIT_W-1:0] val;
        logic [lhp_pkg::LIMIT_W-1:0] base;
        int                          i;
        base = $urandom_range(0, 50);
        for (i = 0; i < lhp_pkg::LIMIT_REGS; i++)
        begin
            case (plan)
                LIM_ONES:
                    val = '1;
                LIM_ZEROS:
                    val = '0;
                LIM_TIGHT:
                begin
                    val  = base;
                    base = base + $urandom_range(0, 300);
                end
                LIM_SHUFFLED:
                    val = $urandom_range(0, 20000);
                LIM_WIDE:
                begin
                    val  = base;
                    base = base + $urandom_range(0, 32'h1000_0000);
                end
                default:
                    val = lhp_pkg::LIMIT_RESET[i];
            endcase
            write_reg(REG_LIMIT_0 + lhp_pkg::CFG_IDX_W'(i), val);
        end
        // An index past the limit registers must change nothing.
        if (plan == LIM_RESET)
            write_reg(REG_UNMAPPED, $urandom());
        // Release the configuration channel after the last write.
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, plus a long hold each time the main flow asks for one.
    always @(posedge clk)
    begin : sink_pacing
        int hold_seen;
        int hold_left;
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Result checker: each result transaction against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        lhp_pkg::result_t got;
        lhp_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = lhp_pkg::result_t'(m_axis_tdata[RESULT_W-1:0]);
            if (m_axis_tdata[lhp_pkg::OUT_TDATA_W-1:RESULT_W] !== '0)
                report_mismatch("zero fill",
                                64'(m_axis_tdata[lhp_pkg::OUT_TDATA_W-1:RESULT_W]), 64'h0);
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 64'(got.answer), 64'h0);
            else
            begin
                want = pending_results.pop_front();
                if (got.answer !== want.answer)
                    report_mismatch("answer", 64'(got.answer), 64'(want.answer));
                if (got.hit !== want.hit)
                    report_mismatch("bucket_hit", 64'(got.hit), 64'(want.hit));
                if (got.count !== want.count)
                    report_mismatch("sample_count", 64'(got.count), 64'(want.count));
                if (got.sum !== want.sum)
                    report_mismatch("sample_sum", got.sum, want.sum);
                if (got.smallest !== want.smallest)
                    report_mismatch("smallest", 64'(got.smallest), 64'(want.smallest));
                if (got.largest !== want.largest)
                    report_mismatch("largest", 64'(got.largest), 64'(want.largest));
            end
        end
    end

    // Watchdog: ends the run when no transaction of any kind happens for too long.
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("latency_histogram_percentile_unit regression: fail");
                $finish;
            end
        end
    end

    // Main flow: reset, directed probes, then random phases under different limits.
    initial
    begin : main_flow
        hist_item_t it;
        int         i;
        int         ph;
        int         n;
        for (i = 0; i < lhp_pkg::LIMIT_REGS; i++)
        begin
            bin_limit[i] = lhp_pkg::LIMIT_RESET[i];
        end
        clear_histogram();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed probes with the reset limits and no idling.
        for (i = 0; i < DIRECTED_COUNT; i++)
        begin
            send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].pct,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            // Limits change only while the block is idle.
            wait_for_results();
            program_limits(PHASE_LIMITS[ph]);
            case (PHASE_PACE[ph])
                PACE_SRC:
                begin
                    src_idle_pct = 65;
                    snk_stall_pct <= 0;
                end
                PACE_SNK:
                begin
                    src_idle_pct = 0;
                    snk_stall_pct <= 65;
                end
                PACE_BOTH:
                begin
                    src_idle_pct = 19;
                    snk_stall_pct <= 19;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_stall_pct <= 0;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS[ph]; n++)
            begin
                // Back-pressure: a long receiver hold, later a full drain by the sender.
                if (ph == PRESSURE_PHASE && n == 30)
                    hold_token <= hold_token + 1;
                if (ph == PRESSURE_PHASE && n == 70)
                    wait_for_results();
                it = random_item();
                send_item(it.op, it.sample, it.pct, 1'b0, UNTYPED);
            end
        end

        wait_for_results();
        repeat (LATENCY_TAIL) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 64'(pending_results.size()), 64'h0);
        if (mismatch_count == 0)
            $display("latency_histogram_percentile_unit regression: pass");
        else
            $display("latency_histogram_percentile_unit regression: fail");
        $finish;
    end

endmodule
